// ===== src/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Direct-mapped cache hit counter package
// Shared widths, sequencer control word and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

    localparam int MAX_LINES = 512;
    localparam int IDX_W     = $clog2(MAX_LINES);
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int CNT_W     = 32;
    localparam int LC_W      = 10;
    localparam int BB_W      = 17;
    localparam int DIV_W     = BB_W;
    localparam int DIV_STEPS = 2;
    localparam int DIV_ITER  = ADDR_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);
    localparam int ENTRY_W   = TAG_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = BB_W;
    localparam int PC_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'd1;

    localparam logic [LC_W-1:0] LC_RESET = LC_W'(512);
    localparam logic [BB_W-1:0] BB_RESET = BB_W'(4);

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_NO_BEAT  = 3'd2,
        C_OP_CLR   = 3'd3,
        C_DIV_BUSY = 3'd4,
        C_CLR_MORE = 3'd5,
        C_OUT_FULL = 3'd6
    } t_cond;

    typedef struct packed {
        logic  in_ready;
        logic  div_start;
        logic  div_line;
        logic  ram_rd;
        logic  clr_wr;
        logic  cnt_clr;
        logic  lookup_upd;
        logic  out_load;
        t_cond cond;
        t_pc   target;
    } t_cw;

    typedef struct packed {
        logic beat;
        logic op_clr;
        logic div_busy;
        logic clr_more;
        logic out_full;
    } t_seq_stat;

endpackage

`default_nettype wire

// ===== src/dmc_req_if.sv =====
// ----------------------------------------------------------------------------
// Access request channel
// Valid/ready channel that carries one cache operation per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dmc_req_if;
    import dmc_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output op, output address, input ready);
    modport sink (input valid, input op, input address, output ready);
endinterface

`default_nettype wire

// ===== src/dmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Access result channel
// Valid/ready channel that carries the hit flag and the running counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dmc_rsp_if;
    import dmc_pkg::*;

    logic             valid;
    logic             ready;
    logic             hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;

    modport source (output valid, output hit, output hit_count, output miss_count,
                    input ready);
    modport sink (input valid, input hit, input hit_count, input miss_count,
                  output ready);
endinterface

`default_nettype wire

// ===== src/dmc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmc_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/dmc_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a 32-bit dividend, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmc_div
    import dmc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [ADDR_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]  i_divisor,
    output logic                   o_busy,
    output logic      [ADDR_W-1:0] o_quotient,
    output logic      [DIV_W-1:0]  o_remainder
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [ADDR_W-1:0]    r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_den;
    logic [ADDR_W-1:0]    n_quo;
    logic [DIV_W-1:0]     n_rem;

    always_comb begin
        logic [DIV_W:0] trial;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            trial = {n_rem, n_quo[ADDR_W-1]};
            n_quo = {n_quo[ADDR_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial    = trial - {1'b0, r_den};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= DIV_CNT_W'(r_cnt + 1'b1);
            if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== src/dmc_seq.sv =====
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over a read-only program of control words with jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmc_seq
    import dmc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_seq_stat i_stat,
    output t_cw            o_cw
);

    localparam t_pc S_INIT_CLR  = 4'd0;
    localparam t_pc S_IDLE      = 4'd1;
    localparam t_pc S_DECODE    = 4'd2;
    localparam t_pc S_DIV_BLK   = 4'd3;
    localparam t_pc S_WAIT_BLK  = 4'd4;
    localparam t_pc S_DIV_LINE  = 4'd5;
    localparam t_pc S_WAIT_LINE = 4'd6;
    localparam t_pc S_LOOKUP    = 4'd7;
    localparam t_pc S_HOLD      = 4'd8;
    localparam t_pc S_UPDATE    = 4'd9;
    localparam t_pc S_CLR_SWEEP = 4'd10;
    localparam t_pc S_CLR_HOLD  = 4'd11;
    localparam t_pc S_CLR_OUT   = 4'd12;

    function automatic t_cw rom_word(input t_pc pc);
        t_cw cw;
        cw        = '0;
        cw.cond   = C_NEXT;
        cw.target = S_IDLE;
        case (pc)
            S_INIT_CLR: begin
                cw.clr_wr = 1'b1;
                cw.cond   = C_CLR_MORE;
                cw.target = S_INIT_CLR;
            end
            S_IDLE: begin
                cw.in_ready = 1'b1;
                cw.cond     = C_NO_BEAT;
                cw.target   = S_IDLE;
            end
            S_DECODE: begin
                cw.cond   = C_OP_CLR;
                cw.target = S_CLR_SWEEP;
            end
            S_DIV_BLK: begin
                cw.div_start = 1'b1;
            end
            S_WAIT_BLK: begin
                cw.cond   = C_DIV_BUSY;
                cw.target = S_WAIT_BLK;
            end
            S_DIV_LINE: begin
                cw.div_start = 1'b1;
                cw.div_line  = 1'b1;
            end
            S_WAIT_LINE: begin
                cw.cond   = C_DIV_BUSY;
                cw.target = S_WAIT_LINE;
            end
            S_LOOKUP: begin
                cw.ram_rd = 1'b1;
            end
            S_HOLD: begin
                cw.cond   = C_OUT_FULL;
                cw.target = S_HOLD;
            end
            S_UPDATE: begin
                cw.lookup_upd = 1'b1;
                cw.out_load   = 1'b1;
                cw.cond       = C_JUMP;
                cw.target     = S_IDLE;
            end
            S_CLR_SWEEP: begin
                cw.clr_wr  = 1'b1;
                cw.cnt_clr = 1'b1;
                cw.cond    = C_CLR_MORE;
                cw.target  = S_CLR_SWEEP;
            end
            S_CLR_HOLD: begin
                cw.cond   = C_OUT_FULL;
                cw.target = S_CLR_HOLD;
            end
            S_CLR_OUT: begin
                cw.out_load = 1'b1;
                cw.cond     = C_JUMP;
                cw.target   = S_IDLE;
            end
            default: begin
                cw.cond   = C_JUMP;
                cw.target = S_IDLE;
            end
        endcase
        return cw;
    endfunction

    t_pc r_pc;
    t_pc n_pc;
    t_cw cw;
    logic take;

    assign cw = rom_word(r_pc);

    always_comb begin
        case (cw.cond)
            C_NEXT:     take = 1'b0;
            C_JUMP:     take = 1'b1;
            C_NO_BEAT:  take = !i_stat.beat;
            C_OP_CLR:   take = i_stat.op_clr;
            C_DIV_BUSY: take = i_stat.div_busy;
            C_CLR_MORE: take = i_stat.clr_more;
            C_OUT_FULL: take = i_stat.out_full;
            default:    take = 1'b1;
        endcase
        n_pc = take ? cw.target : PC_W'(r_pc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_INIT_CLR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_cw = cw;

endmodule

`default_nettype wire

// ===== src/direct_mapped_cache_hit_counter.sv =====
// ----------------------------------------------------------------------------
// Direct-mapped cache hit counter
// Tag store lookup with saturating hit and miss counts, run by microcode.
//
//   Channel   Direction  Beat contents                     Handshake
//   i_req     in         op, address                       valid/ready
//   o_rsp     out        hit, hit_count, miss_count        valid/ready
//   i_cfg_*   in         register index, write data        write enable
//
// An access runs two divisions on the one shared divider, by the block size and
// then by the line count; each holds the program until the divider is idle.
// A clear sweeps all 512 entries of the tag store before its result is loaded.
// After reset the same sweep runs before the first beat is taken.
// A finished result waits in the output register while the next beat is
// accepted; only the final write of a result waits for the sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_cache_hit_counter
    import dmc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    dmc_req_if.sink                   i_req,
    dmc_rsp_if.source                 o_rsp
);

    t_cw       cw;
    t_seq_stat stat;

    logic [LC_W-1:0]   r_line_count;
    logic [BB_W-1:0]   r_block_bytes;
    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_idx;
    logic [TAG_W-1:0]  r_tag;
    logic [IDX_W-1:0]  r_clr_ptr;
    logic [CNT_W-1:0]  r_hits;
    logic [CNT_W-1:0]  r_misses;
    logic              r_out_valid;
    logic              r_out_hit;
    logic [CNT_W-1:0]  r_out_hits;
    logic [CNT_W-1:0]  r_out_misses;
    logic [CNT_W-1:0]  n_hits;
    logic [CNT_W-1:0]  n_misses;

    logic [BB_W-1:0]    bytes_per_block;
    logic [LC_W-1:0]    lines;
    logic               beat;
    logic               div_busy;
    logic [ADDR_W-1:0]  div_quo;
    logic [DIV_W-1:0]   div_rem;
    logic [ADDR_W-1:0]  div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               lookup_hit;
    logic               out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count  <= LC_RESET;
            r_block_bytes <= BB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_COUNT:  r_line_count  <= i_cfg_data[LC_W-1:0];
                CFG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[BB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        bytes_per_block = (r_block_bytes == '0) ? BB_W'(1) : r_block_bytes;
        if (r_line_count == '0) begin
            lines = LC_W'(1);
        end else if (r_line_count > LC_W'(MAX_LINES)) begin
            lines = LC_W'(MAX_LINES);
        end else begin
            lines = r_line_count;
        end
    end

    assign beat        = i_req.valid & cw.in_ready;
    assign i_req.ready = cw.in_ready;
    assign out_full    = r_out_valid & !o_rsp.ready;

    assign stat.beat     = beat;
    assign stat.op_clr   = (r_op == OP_CLEAR);
    assign stat.div_busy = div_busy;
    assign stat.clr_more = (r_clr_ptr != IDX_W'(MAX_LINES - 1));
    assign stat.out_full = out_full;

    dmc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cw    (cw)
    );

    assign div_dividend = cw.div_line ? div_quo : r_addr;
    assign div_divisor  = cw.div_line ? DIV_W'(lines) : bytes_per_block;

    dmc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (cw.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign lookup_hit = ram_rdata[ENTRY_W-1] & (ram_rdata[TAG_W-1:0] == r_tag);
    assign ram_we     = cw.clr_wr | (cw.lookup_upd & !lookup_hit);
    assign ram_waddr  = cw.clr_wr ? r_clr_ptr : r_idx;
    assign ram_wdata  = cw.clr_wr ? '0 : {1'b1, r_tag};

    dmc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LINES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (cw.ram_rd),
        .i_raddr (div_rem[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (cw.cnt_clr) begin
            n_hits   = '0;
            n_misses = '0;
        end else if (cw.lookup_upd) begin
            if (lookup_hit) begin
                n_hits = (r_hits == '1) ? r_hits : CNT_W'(r_hits + 1'b1);
            end else begin
                n_misses = (r_misses == '1) ? r_misses : CNT_W'(r_misses + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op        <= OP_ACCESS;
            r_clr_ptr   <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (beat) begin
                r_op <= i_req.op;
            end
            if (cw.clr_wr) begin
                r_clr_ptr <= IDX_W'(r_clr_ptr + 1'b1);
            end
            r_hits   <= n_hits;
            r_misses <= n_misses;
            if (cw.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat) begin
            r_addr <= i_req.address;
        end
        if (cw.ram_rd) begin
            r_idx <= div_rem[IDX_W-1:0];
            r_tag <= div_quo;
        end
        if (cw.out_load) begin
            r_out_hit    <= cw.lookup_upd & lookup_hit;
            r_out_hits   <= n_hits;
            r_out_misses <= n_misses;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.hit_count  = r_out_hits;
    assign o_rsp.miss_count = r_out_misses;

    a_no_beat_while_dividing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        beat |-> !div_busy
    ) else $error("A beat was accepted while the divider was busy.");

    a_no_result_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cw.out_load |-> !out_full
    ) else $error("A result was loaded over one the sink had not taken.");

    a_index_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        cw.lookup_upd |-> (IDX_W'(r_idx) < IDX_W'(MAX_LINES - 1) ||
                           IDX_W'(r_idx) == IDX_W'(MAX_LINES - 1)) &&
                          ({1'b0, r_idx} < (IDX_W + 1)'(lines))
    ) else $error("The line index is not below the line count.");

    a_counts_monotonic: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !cw.cnt_clr |=> (r_hits >= $past(r_hits)) && (r_misses >= $past(r_misses))
    ) else $error("A counter went down without a clear.");

endmodule

`default_nettype wire

// ===== dv/tb_direct_mapped_cache_hit_counter.sv =====
// ----------------------------------------------------------------------------
// Direct-mapped cache hit counter testbench
// Sends access and clear beats with random gaps, holds off the result channel
// at random, and compares every result beat against a tag store model kept in
// step with the register settings. Several line counts and block sizes are
// used, the range limits and out-of-range values among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_direct_mapped_cache_hit_counter;
    import dmc_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic              op;
        logic [ADDR_W-1:0] address;
        int unsigned       pause;
    } t_access;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } t_tally;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    dmc_req_if req_if();
    dmc_rsp_if rsp_if();

    direct_mapped_cache_hit_counter uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    logic [TAG_W-1:0] tag_copy [MAX_LINES];
    logic             line_live [MAX_LINES];
    logic [CNT_W-1:0] hits_seen;
    logic [CNT_W-1:0] misses_seen;
    logic [LC_W-1:0]  lines_cfg;
    logic [BB_W-1:0]  block_cfg;

    t_access     access_backlog[$];
    t_tally      expected_tallies[$];
    t_access     next_access;
    t_tally      want;
    int unsigned send_pause;
    int unsigned send_calm;
    int unsigned hold_left;
    int unsigned rsp_calm;
    int unsigned quiet_cycles;
    int          mismatches;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] eff_block();
        return (block_cfg == '0) ? 32'd1 : 32'(block_cfg);
    endfunction

    function automatic logic [31:0] eff_lines();
        if (lines_cfg == '0) begin
            return 32'd1;
        end
        return (lines_cfg > LC_W'(MAX_LINES)) ? 32'(MAX_LINES) : 32'(lines_cfg);
    endfunction

    function automatic t_tally lookup_cache(input logic op, input logic [ADDR_W-1:0] address);
        logic [31:0] block_no;
        logic [31:0] line_idx;
        logic [31:0] line_tag;
        t_tally      result;
        int          i;
        result.hit = 1'b0;
        if (op == OP_CLEAR) begin
            for (i = 0; i < MAX_LINES; i++) begin
                tag_copy[i]  = '0;
                line_live[i] = 1'b0;
            end
            hits_seen   = '0;
            misses_seen = '0;
        end else begin
            block_no = address / eff_block();
            line_idx = block_no % eff_lines();
            line_tag = block_no / eff_lines();
            if (line_live[line_idx] && tag_copy[line_idx] == line_tag) begin
                result.hit = 1'b1;
                if (hits_seen != '1) begin
                    hits_seen = hits_seen + 1'b1;
                end
            end else begin
                if (misses_seen != '1) begin
                    misses_seen = misses_seen + 1'b1;
                end
                tag_copy[line_idx]  = line_tag;
                line_live[line_idx] = 1'b1;
            end
        end
        result.hits   = hits_seen;
        result.misses = misses_seen;
        return result;
    endfunction

    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 82) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 24);
        end
        return $urandom_range(25, 120);
    endfunction

    task automatic queue_access(input logic op, input logic [ADDR_W-1:0] address);
        t_access item;
        item.op      = op;
        item.address = address;
        if (send_calm != 0) begin
            send_calm--;
            item.pause = 0;
        end else begin
            if ($urandom_range(0, 39) == 0) begin
                send_calm = $urandom_range(10, 40);
            end
            item.pause = pick_pause();
        end
        access_backlog.push_back(item);
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (access_backlog.size() != 0 || req_if.valid || expected_tallies.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_LINE_COUNT) begin
            lines_cfg = data[LC_W-1:0];
        end else begin
            block_cfg = data[BB_W-1:0];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid   <= 1'b0;
            req_if.op      <= OP_ACCESS;
            req_if.address <= '0;
            send_pause     <= 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) begin
                expected_tallies.push_back(lookup_cache(req_if.op, req_if.address));
            end
            if (send_pause != 0) begin
                req_if.valid <= 1'b0;
                send_pause   <= send_pause - 1;
            end else if (access_backlog.size() != 0) begin
                next_access    = access_backlog.pop_front();
                req_if.valid   <= 1'b1;
                req_if.op      <= next_access.op;
                req_if.address <= next_access.address;
                send_pause     <= next_access.pause;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            rsp_calm     = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_tallies.size() == 0) begin
                    mismatches++;
                    $display("[%0t] result beat with nothing expected: hit %0b hits %0d misses %0d",
                             $time, rsp_if.hit, rsp_if.hit_count, rsp_if.miss_count);
                end else begin
                    want = expected_tallies.pop_front();
                    if (rsp_if.hit !== want.hit) begin
                        mismatches++;
                        $display("[%0t] hit: expected %0b, got %0b", $time, want.hit, rsp_if.hit);
                    end
                    if (rsp_if.hit_count !== want.hits) begin
                        mismatches++;
                        $display("[%0t] hit_count: expected %0d, got %0d",
                                 $time, want.hits, rsp_if.hit_count);
                    end
                    if (rsp_if.miss_count !== want.misses) begin
                        mismatches++;
                        $display("[%0t] miss_count: expected %0d, got %0d",
                                 $time, want.misses, rsp_if.miss_count);
                    end
                end
            end
            if (rsp_calm != 0) begin
                rsp_calm--;
            end else if ($urandom_range(0, 199) == 0) begin
                rsp_calm = $urandom_range(50, 300);
            end
            if (hold_left != 0) begin
                rsp_if.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else if (rsp_calm == 0 && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 1'b0;
                hold_left    <= pick_pause();
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("** direct_mapped_cache_hit_counter: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned       phase;
        int unsigned       n;
        int unsigned       pick;
        int unsigned       k;
        logic [ADDR_W-1:0] hot [8];
        logic [ADDR_W-1:0] last_addr;
        logic [ADDR_W-1:0] addr;
        logic              op;
        longint unsigned   span;
        logic [LC_W-1:0]   lc_pick;
        logic [BB_W-1:0]   bb_pick;

        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_LINE_COUNT;
        cfg_data       = '0;
        req_if.valid   = 1'b0;
        req_if.op      = OP_ACCESS;
        req_if.address = '0;
        rsp_if.ready   = 1'b0;
        send_calm      = 0;
        quiet_cycles   = 0;
        mismatches     = 0;
        lines_cfg      = LC_RESET;
        block_cfg      = BB_RESET;
        void'(lookup_cache(OP_CLEAR, '0));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_access(OP_ACCESS, 32'h0000_0000);
        queue_access(OP_ACCESS, 32'h0000_0003);
        queue_access(OP_ACCESS, 32'hFFFF_FFFF);
        queue_access(OP_ACCESS, 32'hFFFF_FFFC);
        queue_access(OP_ACCESS, 32'h0000_0800);
        queue_access(OP_ACCESS, 32'h0000_0000);
        queue_access(OP_CLEAR, 32'hFFFF_FFFF);
        queue_access(OP_ACCESS, 32'h0000_0000);
        queue_access(OP_ACCESS, 32'h5A5A_A5A5);

        // Tags stay in place when the block size changes.
        wait_idle();
        write_reg(CFG_BLOCK_BYTES, 17'd8);
        queue_access(OP_ACCESS, 32'h0000_0004);
        queue_access(OP_ACCESS, 32'h0000_1000);

        wait_idle();
        write_reg(CFG_LINE_COUNT, 17'h1FC00);
        write_reg(CFG_BLOCK_BYTES, 17'd0);
        queue_access(OP_ACCESS, 32'h0000_0005);
        queue_access(OP_ACCESS, 32'h0000_0005);
        queue_access(OP_ACCESS, 32'h0000_0006);
        queue_access(OP_ACCESS, 32'h0000_0005);

        wait_idle();
        write_reg(CFG_LINE_COUNT, 17'd1023);
        write_reg(CFG_BLOCK_BYTES, 17'd131071);
        queue_access(OP_ACCESS, 32'hFFFF_FFFF);
        queue_access(OP_ACCESS, 32'hFFFF_8000);
        queue_access(OP_ACCESS, 32'hFFFF_7FFF);

        wait_idle();
        write_reg(CFG_LINE_COUNT, 17'd512);
        write_reg(CFG_BLOCK_BYTES, 17'd65536);
        queue_access(OP_ACCESS, 32'hFFFF_0000);
        queue_access(OP_ACCESS, 32'h01FF_0000);
        queue_access(OP_ACCESS, 32'hFFFF_FFFF);

        for (phase = 0; phase < 12; phase++) begin
            wait_idle();
            case (phase)
                0: begin lc_pick = 10'd1;    bb_pick = 17'd1;      end
                1: begin lc_pick = 10'd512;  bb_pick = 17'd65536;  end
                2: begin lc_pick = 10'd0;    bb_pick = 17'd0;      end
                3: begin lc_pick = 10'd1023; bb_pick = 17'd131071; end
                4: begin lc_pick = 10'd513;  bb_pick = 17'd65537;  end
                5: begin lc_pick = 10'd3;    bb_pick = 17'd12;     end
                default: begin
                    lc_pick = $urandom_range(0, 1) ? LC_W'($urandom_range(1, 512))
                                                   : LC_W'($urandom_range(2, 40));
                    bb_pick = ($urandom_range(0, 3) != 0) ? BB_W'($urandom_range(1, 24))
                                                          : BB_W'($urandom_range(1, 131071));
                end
            endcase
            write_reg(CFG_LINE_COUNT, {7'($urandom), lc_pick});
            write_reg(CFG_BLOCK_BYTES, bb_pick);

            for (k = 0; k < 8; k++) begin
                hot[k] = $urandom;
            end
            last_addr = hot[0];
            span = longint'(eff_block()) * longint'(eff_lines());

            // Mostly revisits of a small working set, so lines fill and hit.
            for (n = 0; n < 120; n++) begin
                pick = $urandom_range(0, 99);
                k    = $urandom_range(0, 7);
                op   = OP_ACCESS;
                if (pick < 3) begin
                    op   = OP_CLEAR;
                    addr = $urandom;
                end else if (pick < 48) begin
                    addr = hot[k] - (hot[k] % eff_block()) + ($urandom % eff_block());
                end else if (pick < 68) begin
                    addr = hot[k] + 32'(span * $urandom_range(1, 3));
                end else if (pick < 83) begin
                    addr = last_addr + eff_block();
                end else begin
                    addr = $urandom;
                    if ($urandom_range(0, 3) == 0) begin
                        hot[k] = addr;
                    end
                end
                if (op == OP_ACCESS) begin
                    last_addr = addr;
                end
                queue_access(op, addr);
            end
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** direct_mapped_cache_hit_counter: PASSED **");
        end else begin
            $display("** direct_mapped_cache_hit_counter: FAILED **");
        end
        $finish;
    end

endmodule
